// ===== rtl/track_great_circle_length_macros.svh =====
// Assertion shorthands for the track length block.
// Each expects i_clk and the active-low i_rst_n in the scope where it is used.
`ifndef TRACK_GREAT_CIRCLE_LENGTH_MACROS_SVH
`define TRACK_GREAT_CIRCLE_LENGTH_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define TGCL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define TGCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tgcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tgcl_pkg;

    localparam int CORDIC_STEPS_DEF = 32;
    localparam int ISQRT_STEPS      = 31;

    localparam int LON_W  = 29;
    localparam int LAT_W  = 28;
    localparam int RAD_W  = 24;
    localparam int LEN_W  = 40;
    localparam int SUM_W  = 48;
    localparam int ANG_W  = 31;
    localparam int MAG_W  = 27;
    localparam int DEGK_W = 23;
    localparam int ZP_W   = 50;
    localparam int ZR_W   = ZP_W + 1;
    localparam int CW     = 38;
    localparam int SC_W   = 32;
    localparam int P_W    = 64;
    localparam int T_W    = 34;
    localparam int P3_W   = 66;
    localparam int ARG_W  = 37;
    localparam int RT_W   = 62;
    localparam int LHI_W  = 40;
    localparam int LLO_W  = 56;

    localparam logic signed [ANG_W-1:0] FULL_TURN    = 31'sd360000000;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 31'sd180000000;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 31'sd90000000;
    localparam logic [DEGK_W-1:0]       DEG_TO_RAD_K = 23'd4912665;
    localparam logic signed [CW-1:0]    CORDIC_GAIN  = 38'sd2608131496;
    localparam logic signed [CW-1:0]    HALF_PI      = 38'sd6746518852;
    localparam logic signed [ARG_W-1:0] ARG_ONE      = 37'sd1073741824;
    localparam logic signed [P_W-1:0]   ONE_SQ       = 64'sh1000_0000_0000_0000;
    localparam logic [RAD_W-1:0]        RADIUS_RST   = 24'd6380000;

    localparam logic [1:0] SEL_LAT1 = 2'd0;
    localparam logic [1:0] SEL_LAT2 = 2'd1;
    localparam logic [1:0] SEL_DLON = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_LOAD, S_RED, S_ZMUL, S_ZINIT, S_ROT, S_SCSAVE,
        S_P1, S_P2, S_P3, S_ARG, S_SQ, S_SQRT, S_VINIT, S_VEC, S_ACC,
        S_FIN, S_LEN1, S_LEN2
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_LOAD, OP_RED, OP_ZMUL, OP_ZINIT, OP_ROT,
        OP_SCSAVE, OP_P1, OP_P2, OP_P3, OP_ARG, OP_SQ, OP_SQRT, OP_VINIT,
        OP_VEC, OP_ACC, OP_FIN, OP_LEN1, OP_LEN2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic red_done;
        logic out_busy;
    } t_stat;

    // arctangent of 2^-i in radians at 2^-32
    function automatic logic signed [CW-1:0] f_atan(input logic [5:0] i);
        logic signed [CW-1:0] v;
        case (i)
            6'd0:    v = 38'sd3373259426;
            6'd1:    v = 38'sd1991351318;
            6'd2:    v = 38'sd1052175346;
            6'd3:    v = 38'sd534100635;
            6'd4:    v = 38'sd268086748;
            6'd5:    v = 38'sd134174063;
            6'd6:    v = 38'sd67103403;
            6'd7:    v = 38'sd33553749;
            6'd8:    v = 38'sd16777131;
            6'd9:    v = 38'sd8388597;
            6'd10:   v = 38'sd4194303;
            default: v = (i <= 6'd32) ? (CW'(1) << (6'd32 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tgcl_pt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tgcl_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [tgcl_pkg::LON_W-1:0]   lon_microdeg;
    logic signed [tgcl_pkg::LAT_W-1:0]   lat_microdeg;
    logic                                first_point;
    logic                                last_point;

    modport source (output valid, output lon_microdeg, output lat_microdeg,
                    output first_point, output last_point, input ready);
    modport sink   (input valid, input lon_microdeg, input lat_microdeg,
                    input first_point, input last_point, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgcl_len_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tgcl_len_if;
    logic                        valid;
    logic                        ready;
    logic [tgcl_pkg::LEN_W-1:0]  length_m;
    logic                        overflow;

    modport source (output valid, output length_m, output overflow, input ready);
    modport sink   (input valid, input length_m, input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgcl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tgcl_ctrl #(
    parameter int CORDIC_STEPS = tgcl_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tgcl_pkg::t_stat      i_stat,
    output tgcl_pkg::t_cmd       o_cmd,
    output logic [$clog2((CORDIC_STEPS > tgcl_pkg::ISQRT_STEPS) ? CORDIC_STEPS
                         : tgcl_pkg::ISQRT_STEPS)-1:0] o_idx
);
    localparam int CNT_W = $clog2((CORDIC_STEPS > tgcl_pkg::ISQRT_STEPS) ? CORDIC_STEPS
                                  : tgcl_pkg::ISQRT_STEPS);
    localparam logic [CNT_W-1:0] CNT_ROT_LAST  = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_SQRT_LAST = CNT_W'(tgcl_pkg::ISQRT_STEPS - 1);

    tgcl_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgcl_pkg::S_IDLE;
            r_cnt   <= '0;
            r_sel   <= tgcl_pkg::SEL_LAT1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        case (r_state)
            tgcl_pkg::S_IDLE: begin
                if (i_in_valid) n_state = tgcl_pkg::S_CHK;
            end
            tgcl_pkg::S_CHK: begin
                n_sel   = tgcl_pkg::SEL_LAT1;
                n_state = i_stat.have_prev ? tgcl_pkg::S_LOAD : tgcl_pkg::S_FIN;
            end
            tgcl_pkg::S_LOAD:  n_state = tgcl_pkg::S_RED;
            tgcl_pkg::S_RED: begin
                if (i_stat.red_done) n_state = tgcl_pkg::S_ZMUL;
            end
            tgcl_pkg::S_ZMUL:  n_state = tgcl_pkg::S_ZINIT;
            tgcl_pkg::S_ZINIT: begin
                n_cnt   = '0;
                n_state = tgcl_pkg::S_ROT;
            end
            tgcl_pkg::S_ROT: begin
                if (r_cnt == CNT_ROT_LAST) n_state = tgcl_pkg::S_SCSAVE;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            tgcl_pkg::S_SCSAVE: begin
                if (r_sel == tgcl_pkg::SEL_DLON) begin
                    n_state = tgcl_pkg::S_P1;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = tgcl_pkg::S_LOAD;
                end
            end
            tgcl_pkg::S_P1:    n_state = tgcl_pkg::S_P2;
            tgcl_pkg::S_P2:    n_state = tgcl_pkg::S_P3;
            tgcl_pkg::S_P3:    n_state = tgcl_pkg::S_ARG;
            tgcl_pkg::S_ARG:   n_state = tgcl_pkg::S_SQ;
            tgcl_pkg::S_SQ: begin
                n_cnt   = '0;
                n_state = tgcl_pkg::S_SQRT;
            end
            tgcl_pkg::S_SQRT: begin
                if (r_cnt == CNT_SQRT_LAST) n_state = tgcl_pkg::S_VINIT;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            tgcl_pkg::S_VINIT: begin
                n_cnt   = '0;
                n_state = tgcl_pkg::S_VEC;
            end
            tgcl_pkg::S_VEC: begin
                if (r_cnt == CNT_ROT_LAST) n_state = tgcl_pkg::S_ACC;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            tgcl_pkg::S_ACC:   n_state = tgcl_pkg::S_FIN;
            tgcl_pkg::S_FIN: begin
                n_state = i_stat.last ? tgcl_pkg::S_LEN1 : tgcl_pkg::S_IDLE;
            end
            tgcl_pkg::S_LEN1:  n_state = tgcl_pkg::S_LEN2;
            tgcl_pkg::S_LEN2: begin
                if (!i_stat.out_busy) n_state = tgcl_pkg::S_IDLE;
            end
            default:           n_state = tgcl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == tgcl_pkg::S_IDLE);
        o_idx      = r_cnt;
        o_cmd.sel  = r_sel;
        case (r_state)
            tgcl_pkg::S_IDLE:   o_cmd.op = i_in_valid ? tgcl_pkg::OP_ACCEPT : tgcl_pkg::OP_NONE;
            tgcl_pkg::S_CHK:    o_cmd.op = tgcl_pkg::OP_NONE;
            tgcl_pkg::S_LOAD:   o_cmd.op = tgcl_pkg::OP_LOAD;
            tgcl_pkg::S_RED:    o_cmd.op = tgcl_pkg::OP_RED;
            tgcl_pkg::S_ZMUL:   o_cmd.op = tgcl_pkg::OP_ZMUL;
            tgcl_pkg::S_ZINIT:  o_cmd.op = tgcl_pkg::OP_ZINIT;
            tgcl_pkg::S_ROT:    o_cmd.op = tgcl_pkg::OP_ROT;
            tgcl_pkg::S_SCSAVE: o_cmd.op = tgcl_pkg::OP_SCSAVE;
            tgcl_pkg::S_P1:     o_cmd.op = tgcl_pkg::OP_P1;
            tgcl_pkg::S_P2:     o_cmd.op = tgcl_pkg::OP_P2;
            tgcl_pkg::S_P3:     o_cmd.op = tgcl_pkg::OP_P3;
            tgcl_pkg::S_ARG:    o_cmd.op = tgcl_pkg::OP_ARG;
            tgcl_pkg::S_SQ:     o_cmd.op = tgcl_pkg::OP_SQ;
            tgcl_pkg::S_SQRT:   o_cmd.op = tgcl_pkg::OP_SQRT;
            tgcl_pkg::S_VINIT:  o_cmd.op = tgcl_pkg::OP_VINIT;
            tgcl_pkg::S_VEC:    o_cmd.op = tgcl_pkg::OP_VEC;
            tgcl_pkg::S_ACC:    o_cmd.op = tgcl_pkg::OP_ACC;
            tgcl_pkg::S_FIN:    o_cmd.op = tgcl_pkg::OP_FIN;
            tgcl_pkg::S_LEN1:   o_cmd.op = tgcl_pkg::OP_LEN1;
            tgcl_pkg::S_LEN2:   o_cmd.op = i_stat.out_busy ? tgcl_pkg::OP_NONE
                                                           : tgcl_pkg::OP_LEN2;
            default:            o_cmd.op = tgcl_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tgcl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tgcl_dp #(
    parameter int CORDIC_STEPS = tgcl_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tgcl_pkg::t_cmd                      i_cmd,
    input  logic [$clog2((CORDIC_STEPS > tgcl_pkg::ISQRT_STEPS) ? CORDIC_STEPS
                         : tgcl_pkg::ISQRT_STEPS)-1:0] i_idx,
    input  logic signed [tgcl_pkg::LON_W-1:0]   i_lon,
    input  logic signed [tgcl_pkg::LAT_W-1:0]   i_lat,
    input  logic                                i_first,
    input  logic                                i_last,
    input  logic                                i_cfg_we,
    input  logic [tgcl_pkg::RAD_W-1:0]          i_cfg_wdata,
    output tgcl_pkg::t_stat                     o_stat,
    tgcl_len_if.source                          o_len
);
    localparam int ANG_W = tgcl_pkg::ANG_W;
    localparam int CW    = tgcl_pkg::CW;
    localparam int SC_W  = tgcl_pkg::SC_W;
    localparam int RT_W  = tgcl_pkg::RT_W;
    localparam int SUM_W = tgcl_pkg::SUM_W;
    localparam int LEN_W = tgcl_pkg::LEN_W;

    // control state
    logic [tgcl_pkg::RAD_W-1:0]         r_radius;
    logic                               r_have_prev;
    logic [SUM_W-1:0]                   r_sum;
    logic                               r_sat;
    logic signed [tgcl_pkg::LON_W-1:0]  r_prev_lon;
    logic signed [tgcl_pkg::LAT_W-1:0]  r_prev_lat;
    logic                               r_out_valid;

    // working registers
    logic signed [tgcl_pkg::LON_W-1:0]  r_lon;
    logic signed [tgcl_pkg::LAT_W-1:0]  r_lat;
    logic                               r_last;
    logic signed [ANG_W-1:0]            r_ang;
    logic                               r_neg;
    logic                               r_mneg;
    logic [tgcl_pkg::ZP_W-1:0]          r_zprod;
    logic signed [CW-1:0]               r_x, r_y, r_z;
    logic signed [SC_W-1:0]             r_s1, r_c1, r_s2, r_c2, r_cl;
    logic signed [tgcl_pkg::P_W-1:0]    r_p1, r_p2;
    logic signed [tgcl_pkg::P3_W-1:0]   r_p3;
    logic signed [SC_W-1:0]             r_a;
    logic [RT_W-1:0]                    r_v, r_root;
    logic [tgcl_pkg::LHI_W-1:0]         r_lhi;
    logic [tgcl_pkg::LLO_W-1:0]         r_llo;
    logic [LEN_W-1:0]                   r_len;
    logic                               r_ovf;

    logic [5:0]                         w_idx6;
    logic signed [ANG_W-1:0]            w_load, w_red_ang;
    logic                               w_red_fold, w_red_done;
    logic [tgcl_pkg::MAG_W-1:0]         w_mag;
    logic [tgcl_pkg::ZR_W-1:0]          w_zr;
    logic signed [CW-1:0]               w_zpos;
    logic signed [CW-1:0]               w_dx, w_dy, w_at, w_xs, w_ys, w_cv, w_sv;
    logic                               w_up;
    logic signed [tgcl_pkg::P_W-1:0]    w_p1, w_p2, w_asq;
    logic signed [tgcl_pkg::T_W-1:0]    w_t;
    logic signed [tgcl_pkg::P3_W-1:0]   w_p3;
    logic signed [tgcl_pkg::ARG_W-1:0]  w_argsum, w_argc;
    logic [6:0]                         w_shamt;
    logic [RT_W-1:0]                    w_bit, w_trial;
    logic signed [CW-1:0]               w_root_s, w_a_s;
    logic [SUM_W:0]                     w_sum_ext;
    logic [tgcl_pkg::LLO_W:0]           w_llor;
    logic [LEN_W:0]                     w_lenr;

    assign w_idx6 = 6'(i_idx);

    always_comb begin
        case (i_cmd.sel)
            tgcl_pkg::SEL_LAT1: w_load = ANG_W'(r_prev_lat);
            tgcl_pkg::SEL_LAT2: w_load = ANG_W'(r_lat);
            tgcl_pkg::SEL_DLON: w_load = ANG_W'(r_lon) - ANG_W'(r_prev_lon);
            default:            w_load = '0;
        endcase
    end

    // wrap into a half turn either way, then fold into a quarter turn
    always_comb begin
        w_red_ang  = r_ang;
        w_red_fold = 1'b0;
        if (r_ang > tgcl_pkg::HALF_TURN) begin
            w_red_ang = r_ang - tgcl_pkg::FULL_TURN;
        end else if (r_ang < -tgcl_pkg::HALF_TURN) begin
            w_red_ang = r_ang + tgcl_pkg::FULL_TURN;
        end else if (r_ang > tgcl_pkg::QUARTER_TURN) begin
            w_red_ang  = r_ang - tgcl_pkg::HALF_TURN;
            w_red_fold = 1'b1;
        end else if (r_ang < -tgcl_pkg::QUARTER_TURN) begin
            w_red_ang  = r_ang + tgcl_pkg::HALF_TURN;
            w_red_fold = 1'b1;
        end
    end

    assign w_red_done = !(r_ang > tgcl_pkg::QUARTER_TURN) &&
                        !(r_ang < -tgcl_pkg::QUARTER_TURN);

    assign w_mag  = tgcl_pkg::MAG_W'(r_ang[ANG_W-1] ? -r_ang : r_ang);
    assign w_zr   = {1'b0, r_zprod} + tgcl_pkg::ZR_W'(32768);
    assign w_zpos = CW'($signed({1'b0, w_zr[tgcl_pkg::ZR_W-1:16]}));

    assign w_dx = r_y >>> w_idx6;
    assign w_dy = r_x >>> w_idx6;
    assign w_at = tgcl_pkg::f_atan(w_idx6);
    assign w_up = (i_cmd.op == tgcl_pkg::OP_ROT) ? !r_z[CW-1] : r_y[CW-1];

    assign w_xs = r_x >>> 2;
    assign w_ys = r_y >>> 2;
    assign w_cv = r_neg ? -w_xs : w_xs;
    assign w_sv = r_neg ? -w_ys : w_ys;

    assign w_p1 = r_s1 * r_s2;
    assign w_p2 = r_c1 * r_c2;
    assign w_t  = tgcl_pkg::T_W'(r_p2 >>> 30);
    assign w_p3 = w_t * r_cl;

    assign w_argsum = tgcl_pkg::ARG_W'(r_p1 >>> 30) + tgcl_pkg::ARG_W'(r_p3 >>> 30);
    assign w_argc   = (w_argsum > tgcl_pkg::ARG_ONE)  ? tgcl_pkg::ARG_ONE :
                      (w_argsum < -tgcl_pkg::ARG_ONE) ? -tgcl_pkg::ARG_ONE : w_argsum;

    assign w_asq   = r_a * r_a;
    assign w_shamt = 7'd60 - {w_idx6, 1'b0};
    assign w_bit   = RT_W'(1) << w_shamt;
    assign w_trial = r_root + w_bit;

    assign w_root_s = CW'($signed({1'b0, r_root[SC_W-2:0]}));
    assign w_a_s    = CW'(r_a);

    assign w_sum_ext = {1'b0, r_sum} +
                       (r_z[CW-1] ? '0 : (SUM_W + 1)'(r_z[CW-2:0]));

    assign w_llor = {1'b0, r_llo} + (tgcl_pkg::LLO_W + 1)'(32'h8000_0000);
    assign w_lenr = {1'b0, r_lhi} + (LEN_W + 1)'(w_llor[tgcl_pkg::LLO_W:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= tgcl_pkg::RADIUS_RST;
            r_have_prev <= 1'b0;
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_prev_lon  <= '0;
            r_prev_lat  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_radius <= i_cfg_wdata;
            case (i_cmd.op)
                tgcl_pkg::OP_ACCEPT: begin
                    if (i_first) begin
                        r_sum       <= '0;
                        r_sat       <= 1'b0;
                        r_have_prev <= 1'b0;
                    end
                end
                tgcl_pkg::OP_ACC: begin
                    if (w_sum_ext[SUM_W]) begin
                        r_sum <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= w_sum_ext[SUM_W-1:0];
                    end
                end
                tgcl_pkg::OP_FIN: begin
                    r_prev_lon  <= r_lon;
                    r_prev_lat  <= r_lat;
                    r_have_prev <= 1'b1;
                end
                tgcl_pkg::OP_LEN2: begin
                    r_sum       <= '0;
                    r_sat       <= 1'b0;
                    r_have_prev <= 1'b0;
                end
                default: ;
            endcase
            if (i_cmd.op == tgcl_pkg::OP_LEN2) r_out_valid <= 1'b1;
            else if (o_len.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            tgcl_pkg::OP_ACCEPT: begin
                r_lon  <= i_lon;
                r_lat  <= i_lat;
                r_last <= i_last;
            end
            tgcl_pkg::OP_LOAD: begin
                r_ang <= w_load;
                r_neg <= 1'b0;
            end
            tgcl_pkg::OP_RED: begin
                r_ang <= w_red_ang;
                if (w_red_fold) r_neg <= 1'b1;
            end
            tgcl_pkg::OP_ZMUL: begin
                r_mneg  <= r_ang[ANG_W-1];
                r_zprod <= w_mag * tgcl_pkg::DEG_TO_RAD_K;
            end
            tgcl_pkg::OP_ZINIT: begin
                r_x <= tgcl_pkg::CORDIC_GAIN;
                r_y <= '0;
                r_z <= r_mneg ? -w_zpos : w_zpos;
            end
            tgcl_pkg::OP_ROT, tgcl_pkg::OP_VEC: begin
                r_x <= w_up ? r_x - w_dx : r_x + w_dx;
                r_y <= w_up ? r_y + w_dy : r_y - w_dy;
                r_z <= w_up ? r_z - w_at : r_z + w_at;
            end
            tgcl_pkg::OP_SCSAVE: begin
                case (i_cmd.sel)
                    tgcl_pkg::SEL_LAT1: begin
                        r_s1 <= SC_W'(w_sv);
                        r_c1 <= SC_W'(w_cv);
                    end
                    tgcl_pkg::SEL_LAT2: begin
                        r_s2 <= SC_W'(w_sv);
                        r_c2 <= SC_W'(w_cv);
                    end
                    default: begin
                        r_cl <= SC_W'(w_cv);
                    end
                endcase
            end
            tgcl_pkg::OP_P1:  r_p1 <= w_p1;
            tgcl_pkg::OP_P2:  r_p2 <= w_p2;
            tgcl_pkg::OP_P3:  r_p3 <= w_p3;
            tgcl_pkg::OP_ARG: r_a  <= SC_W'(w_argc);
            tgcl_pkg::OP_SQ: begin
                r_v    <= RT_W'(tgcl_pkg::ONE_SQ - w_asq);
                r_root <= '0;
            end
            tgcl_pkg::OP_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v    <= r_v - w_trial;
                    r_root <= (r_root >> 1) + w_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
            end
            tgcl_pkg::OP_VINIT: begin
                if (r_a[SC_W-1]) begin
                    r_x <= w_root_s;
                    r_y <= -w_a_s;
                    r_z <= tgcl_pkg::HALF_PI;
                end else begin
                    r_x <= w_a_s;
                    r_y <= w_root_s;
                    r_z <= '0;
                end
            end
            tgcl_pkg::OP_LEN1: begin
                r_lhi <= r_sum[SUM_W-1:32] * r_radius;
                r_llo <= r_sum[31:0] * r_radius;
            end
            tgcl_pkg::OP_LEN2: begin
                r_len <= w_lenr[LEN_W] ? '1 : w_lenr[LEN_W-1:0];
                r_ovf <= r_sat;
            end
            default: ;
        endcase
    end

    assign o_stat.have_prev = r_have_prev;
    assign o_stat.last      = r_last;
    assign o_stat.red_done  = w_red_done;
    assign o_stat.out_busy  = r_out_valid && !o_len.ready;

    assign o_len.valid    = r_out_valid;
    assign o_len.length_m = r_len;
    assign o_len.overflow = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/track_great_circle_length.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Great-circle track length. Feed track points (longitude and latitude in
// microdegrees) on i_pt; first_point restarts the sum, and on a point with
// last_point the length in whole meters (sum of central angles times the
// radius in i_cfg_wdata) comes out on o_len, with overflow set if the angle
// sum saturated. A point that has a previous point passes through the angle
// reduction of each pass, the one shared CORDIC stage, which runs three
// sine/cosine passes and one arccosine pass, and the one-bit-per-cycle square
// root; a point without a previous point skips them. A last point also waits
// while an earlier result still waits on o_len. One point is taken at a time,
// and the next point is taken while a result waits on o_len.
module track_great_circle_length #(
    parameter int CORDIC_STEPS = tgcl_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tgcl_pkg::RAD_W-1:0]  i_cfg_wdata,
    tgcl_pt_if.sink                     i_pt,
    tgcl_len_if.source                  o_len
);
    localparam int CNT_W = $clog2((CORDIC_STEPS > tgcl_pkg::ISQRT_STEPS) ? CORDIC_STEPS
                                  : tgcl_pkg::ISQRT_STEPS);

    tgcl_pkg::t_cmd   w_cmd;
    tgcl_pkg::t_stat  w_stat;
    logic [CNT_W-1:0] w_idx;

    tgcl_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (i_pt.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    tgcl_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .i_lon       (i_pt.lon_microdeg),
        .i_lat       (i_pt.lat_microdeg),
        .i_first     (i_pt.first_point),
        .i_last      (i_pt.last_point),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (w_stat),
        .o_len       (o_len)
    );

endmodule

`default_nettype wire

// ===== rtl/tgcl_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "track_great_circle_length_macros.svh"

module tgcl_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    `TGCL_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result word dropped while stalled")
    `TGCL_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready, "point word taken while busy")
    `TGCL_ASSERT_SAME(a_no_early_result, $rose(i_out_valid), !$past(i_in_valid && i_in_ready), "result right after a take")
    `TGCL_ASSERT_SAME(a_reset_idle, $past(!i_rst_n), !i_out_valid, "result word out of reset")
endmodule

bind track_great_circle_length tgcl_chk u_tgcl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_len.valid),
    .i_out_ready (o_len.ready)
);

`default_nettype wire
